// File: hdl/pcl_pkg.sv
// pcl_pkg: shared types, codes and constants for the PIN check with lockout block.
// No dependencies; imported by every module of the block.
`default_nettype none

package pcl_pkg;

  localparam int PIN_LEN_DEFAULT = 16;

  localparam int CHAR_W     = 8;
  localparam int KIND_W     = 2;
  localparam int GLEN_W     = 5;
  localparam int STREAK_W   = 8;
  localparam int SECS_W     = 12;
  localparam int TIME_W     = 32;
  localparam int LOCK_MS_W  = 22;   // 4095 s * 1000 fits
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int STATUS_W   = 2;

  // input kind codes; the fourth code is ignored
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_LO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_HI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRONG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_SECS = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_WRONG   = 2'd1,
    STAT_LOCKED  = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  // reset values
  localparam logic [GLEN_W-1:0]   PIN_LEN_RST   = 5'd6;
  localparam logic [STREAK_W-1:0] MAX_WRONG_RST = 8'd5;
  localparam logic [SECS_W-1:0]   LOCK_SECS_RST = 12'd60;

  // arithmetic constants
  localparam int MS_PER_SEC  = 1000;
  localparam int ROUND_UP    = 999;
  localparam int RETRY_MAX   = 4095;
  localparam int SAT_LIMIT   = 4095000;   // above this, ceil(ms/1000) > 4095
  localparam int GLEN_MAX    = 31;
  localparam int STREAK_MAX  = 255;
  // floor(v/1000) = (v * RECIP) >> RECIP_SHIFT, exact for v < 2^22
  localparam int RECIP       = 4294968;
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 32;

  // attempt stage result handed to the retry stage
  typedef struct packed {
    status_t                status;
    logic                   div;    // retry comes from the time left
    logic                   sat;    // time left saturates the retry count
    logic [LOCK_MS_W-1:0]   rnd;    // time left plus round-up term
    logic [SECS_W-1:0]      secs;   // retry for all other results
  } att_res_t;

endpackage

`default_nettype wire

// File: hdl/pcl_attempt.sv
// pcl_attempt: input register, configuration registers, attempt state and the
// registered per-attempt result. Depends on pcl_pkg.
`default_nettype none

module pcl_attempt import pcl_pkg::*; #(
  parameter int MAX_PIN_LEN = PIN_LEN_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic                  in_last_char,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  res_valid,
  input  logic                  res_ready,
  output att_res_t              res
);

  localparam int IDX_W = (MAX_PIN_LEN > 1) ? $clog2(MAX_PIN_LEN) : 1;
  localparam int HALF  = CFG_DATA_W / CHAR_W;

  // input register
  logic                  a_valid_r;
  logic [KIND_W-1:0]     a_kind_r;
  logic [CHAR_W-1:0]     a_char_r;
  logic                  a_last_r;
  logic [TIME_W-1:0]     a_now_r;

  // configuration
  logic [CHAR_W-1:0]     pin_r [MAX_PIN_LEN];
  logic [GLEN_W-1:0]     pin_len_r;
  logic [STREAK_W-1:0]   max_wrong_r;
  logic [SECS_W-1:0]     lock_secs_r;
  logic [LOCK_MS_W-1:0]  lock_ms_r;

  // attempt state
  logic [STREAK_W-1:0]   streak_r, streak_nxt;
  logic [TIME_W-1:0]     until_r, until_nxt;
  logic [GLEN_W-1:0]     glen_r, glen_nxt;
  logic                  mis_r, mis_nxt;

  // result register
  logic                  b_valid_r;
  att_res_t              b_res_r;

  logic                  has_res;
  logic                  a_proc, a_free, b_free;
  logic [IDX_W-1:0]      cidx;
  logic                  in_range;
  logic [CHAR_W-1:0]     stored;
  logic [GLEN_W-1:0]     glen_c;
  logic                  mis_c;
  logic [TIME_W-1:0]     diff;
  logic                  lock_on, expired;
  logic [STREAK_W-1:0]   streak_base, streak_inc;
  logic                  match;
  logic [TIME_W-1:0]     deadline, deadline_fix;
  att_res_t              res_c;

  assign cidx     = glen_r[IDX_W-1:0];
  assign in_range = (glen_r < GLEN_W'(MAX_PIN_LEN));
  assign stored   = (in_range && (glen_r < pin_len_r)) ? pin_r[cidx] : '0;

  // lock test against the registered deadline
  assign diff    = until_r - a_now_r;
  assign lock_on = (until_r != '0) && (diff != '0) && !diff[TIME_W-1];
  assign expired = (until_r != '0) && !lock_on;

  assign streak_base = expired ? '0 : streak_r;
  assign streak_inc  = (streak_base != STREAK_W'(STREAK_MAX)) ? streak_base + 1'b1
                                                              : streak_base;

  assign deadline     = a_now_r + TIME_W'(lock_ms_r);
  assign deadline_fix = (deadline == '0) ? TIME_W'(1) : deadline;

  always_comb begin
    has_res = 1'b0;
    glen_c  = glen_r;
    mis_c   = mis_r;
    case (a_kind_r) inside
      KIND_CHAR: begin
        mis_c   = mis_r | (in_range && (a_char_r != stored));
        glen_c  = (glen_r != GLEN_W'(GLEN_MAX)) ? glen_r + 1'b1 : glen_r;
        has_res = a_last_r;
      end
      KIND_END, KIND_NONE: begin
        has_res = 1'b1;
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  assign match = !mis_c && (glen_c == pin_len_r);

  always_comb begin
    glen_nxt   = glen_c;
    mis_nxt    = mis_c;
    streak_nxt = streak_r;
    until_nxt  = until_r;
    res_c.status = STAT_WRONG;
    res_c.div    = 1'b0;
    res_c.sat    = (diff > TIME_W'(SAT_LIMIT));
    res_c.rnd    = diff[LOCK_MS_W-1:0] + LOCK_MS_W'(ROUND_UP);
    res_c.secs   = '0;
    if (has_res) begin
      glen_nxt   = '0;
      mis_nxt    = 1'b0;
      until_nxt  = expired ? '0 : until_r;
      streak_nxt = streak_base;
      if (lock_on) begin
        res_c.status = STAT_LOCKED;
        res_c.div    = 1'b1;
      end else if (a_kind_r == KIND_NONE) begin
        res_c.status = STAT_MISSING;
      end else if (match) begin
        streak_nxt   = '0;
        res_c.status = STAT_OK;
      end else begin
        streak_nxt = streak_inc;
        if (streak_inc >= max_wrong_r) begin
          until_nxt    = deadline_fix;
          res_c.status = STAT_LOCKED;
          res_c.secs   = lock_secs_r;
        end else begin
          res_c.status = STAT_WRONG;
        end
      end
    end
  end

  // items without a result never wait on the result register
  assign b_free   = !b_valid_r || res_ready;
  assign a_proc   = a_valid_r && (b_free || !has_res);
  assign a_free   = !a_valid_r || a_proc;
  assign in_ready = a_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      streak_r    <= '0;
      until_r     <= '0;
      glen_r      <= '0;
      mis_r       <= 1'b0;
      pin_len_r   <= PIN_LEN_RST;
      max_wrong_r <= MAX_WRONG_RST;
      lock_secs_r <= LOCK_SECS_RST;
      lock_ms_r   <= LOCK_MS_W'(LOCK_SECS_RST) * LOCK_MS_W'(MS_PER_SEC);
      for (int j = 0; j < MAX_PIN_LEN; j++) begin
        pin_r[j] <= '0;
      end
    end else begin
      if (a_free) begin
        a_valid_r <= in_valid;
      end
      if (a_proc && has_res) begin
        b_valid_r <= 1'b1;
      end else if (res_ready) begin
        b_valid_r <= 1'b0;
      end
      if (a_proc) begin
        streak_r <= streak_nxt;
        until_r  <= until_nxt;
        glen_r   <= glen_nxt;
        mis_r    <= mis_nxt;
      end
      // writes must arrive only while idle, which the block does not enforce; PIN writes drop any lockout
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PIN_LO: begin
            for (int j = 0; j < MAX_PIN_LEN; j++) begin
              if (j < HALF) begin
                pin_r[j] <= cfg_wdata[CHAR_W*(j % HALF) +: CHAR_W];
              end
            end
            streak_r <= '0;
            until_r  <= '0;
          end
          CFG_PIN_HI: begin
            for (int j = 0; j < MAX_PIN_LEN; j++) begin
              if (j >= HALF) begin
                pin_r[j] <= cfg_wdata[CHAR_W*(j % HALF) +: CHAR_W];
              end
            end
            streak_r <= '0;
            until_r  <= '0;
          end
          CFG_PIN_LEN: begin
            pin_len_r <= cfg_wdata[GLEN_W-1:0];
            streak_r  <= '0;
            until_r   <= '0;
          end
          CFG_MAX_WRONG: begin
            max_wrong_r <= cfg_wdata[STREAK_W-1:0];
          end
          CFG_LOCK_SECS: begin
            lock_secs_r <= cfg_wdata[SECS_W-1:0];
            lock_ms_r   <= LOCK_MS_W'(cfg_wdata[SECS_W-1:0]) * LOCK_MS_W'(MS_PER_SEC);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_free) begin
      a_kind_r <= in_kind;
      a_char_r <= in_char_code;
      a_last_r <= in_last_char;
      a_now_r  <= in_now_ms;
    end
    if (a_proc && has_res) begin
      b_res_r <= res_c;
    end
  end

  assign res_valid = b_valid_r;
  assign res       = b_res_r;

endmodule

`default_nettype wire

// File: hdl/pcl_retry.sv
// pcl_retry: converts the time left into whole seconds (reciprocal multiply)
// and holds the output register. Depends on pcl_pkg.
`default_nettype none

module pcl_retry import pcl_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  output logic                res_ready,
  input  att_res_t            res,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SECS_W-1:0]   out_retry_seconds
);

  localparam int PROD_W = LOCK_MS_W + RECIP_W;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [SECS_W-1:0]   out_retry_r;

  logic [PROD_W-1:0]   prod;
  logic [SECS_W-1:0]   quot;
  logic [SECS_W-1:0]   retry_c;

  assign prod = PROD_W'(res.rnd) * PROD_W'(RECIP);
  assign quot = prod[RECIP_SHIFT +: SECS_W];

  always_comb begin
    if (!res.div) begin
      retry_c = res.secs;
    end else if (res.sat) begin
      retry_c = SECS_W'(RETRY_MAX);
    end else begin
      retry_c = quot;
    end
  end

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_status_r <= res.status;
      out_retry_r  <= retry_c;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_retry_seconds = out_retry_r;

endmodule

`default_nettype wire

// File: hdl/pin_check_with_lockout_unit.sv
// pin_check_with_lockout_unit: top level of the PIN check with lockout block.
// Depends on pcl_pkg, pcl_attempt and pcl_retry.
//
// Takes one input item per cycle while the result path is not stalled: guess
// characters, end-of-guess marks and missing-guess marks, each stamped with a
// millisecond time. Every finished attempt produces one result (status and
// seconds left until unlock); other items produce none. An item goes through
// three registers (input, attempt, output); the input register loads at the
// transfer edge, and the result then moves into the attempt and output
// registers in turn. The attempt stage updates the wrong streak, lock deadline
// and guess compare state once per item, which sets the one-item-per-cycle
// rate; the seconds-left division is done in the output stage by a reciprocal
// multiply. Configuration writes take effect at once and must be issued only
// while no attempt is in flight; writing any PIN register clears the wrong
// streak and any running lockout.
`default_nettype none

module pin_check_with_lockout_unit import pcl_pkg::*; #(
  parameter int MAX_PIN_LEN = PIN_LEN_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic                  in_last_char,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SECS_W-1:0]     out_retry_seconds,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic     res_valid;
  logic     res_ready;
  att_res_t res;

  pcl_attempt #(
    .MAX_PIN_LEN (MAX_PIN_LEN)
  ) u_attempt (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .in_now_ms    (in_now_ms),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  pcl_retry u_retry (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res               (res),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_retry_seconds (out_retry_seconds)
  );

endmodule

`default_nettype wire

// File: hdl/pcl_checker.sv
// pcl_checker: port-level assertions for pin_check_with_lockout_unit, bound
// to the top level below. Depends on pcl_pkg.
`default_nettype none

module pcl_checker import pcl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic                  in_last_char,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic [SECS_W-1:0]     out_retry_seconds
);

  // a waiting input transfer holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_kind) && $stable(in_char_code)
                              && $stable(in_last_char) && $stable(in_now_ms))
    else $error("input changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
                                && $stable(out_retry_seconds))
    else $error("result changed while stalled");

  // only a locked status carries seconds left
  a_retry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_LOCKED) |-> out_retry_seconds == '0)
    else $error("nonzero retry seconds on unlocked status");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // the input side is open as soon as reset ends
  a_ready_after_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind pin_check_with_lockout_unit pcl_checker u_pcl_checker (.*);

`default_nettype wire
